FILE: design/pcg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pcg_pkg;

   localparam logic [63:0] PCG_MULT   = 64'd6364136223846793005;
   localparam logic [63:0] PCG_INC    = 64'd1442695040888963407;
   localparam logic [63:0] TAG_GEN    = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] TAG_POP    = 64'hd1b54a32d192ed03;
   localparam logic [63:0] TAG_DOM    = 64'h94d049bb133111eb;
   localparam logic [63:0] TAG_STATE  = 64'ha0761d6478bd642f;
   localparam logic [63:0] TAG_STREAM = 64'he7037ed1a0b428db;
   localparam logic [63:0] MIX_M1     = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_M2     = 64'h94d049bb133111eb;
   localparam logic [32:0] ONE_FIXED  = 33'h1_0000_0000;
   localparam int unsigned STREAM_ROT = 23;
   localparam int unsigned QUEUE_DEPTH = 2;

   // configuration register indexes
   localparam logic [1:0] CSR_ROOT_SEED    = 2'd0;
   localparam logic [1:0] CSR_DOMAIN_FIRST = 2'd1;
   localparam logic [1:0] CSR_DOMAIN_LAST  = 2'd2;

   typedef enum logic [2:0] {
      OP_SEED   = 3'd0,
      OP_DERIVE = 3'd1,
      OP_NEXT   = 3'd2,
      OP_UNIF   = 3'd3,
      OP_PROB   = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_UNSEEDED = 2'd1,
      ST_BADARG   = 2'd2
   } status_type;

   // classified command handed from the front to the back
   typedef enum logic [2:0] {
      CMD_FAIL, CMD_SEED, CMD_DERIVE, CMD_NEXT, CMD_UNIF, CMD_PROB
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      status_type  fail_status;
      logic [63:0] arg_a;      // seed, or generation
      logic [63:0] arg_b;      // population slot, or bound
      logic [7:0]  dom;
      logic [32:0] chance;
   } work_type;

   typedef enum logic [4:0] {
      B_IDLE, B_STEP_MUL, B_STEP_ADD, B_SEED_ADD,
      B_MIX_XOR, B_MIX_MUL1, B_MIX_X2, B_MIX_MUL2, B_MIX_DONE,
      B_LIM_INIT, B_LIM_DIV, B_DIV_DONE, B_SAMPLE_CHK, B_RESULT
   } back_state_type;

   typedef struct packed {
      logic        valid;
      status_type  status;
      logic [63:0] value;
      logic        hit;
   } result_type;

endpackage
`default_nettype wire

FILE: design/pcg32_random_source_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// PCG32 XSH-RR random source. Items enter a two-entry queue after a front end
// classifies them; a back end sequencer performs them one at a time, starting
// an item only once the result register is free. Every LCG step and splitmix
// multiply is a 64-bit low-half product built from three 32x32 partial
// products. Derive runs six splitmix passes, and uniform uses a bit-serial
// restoring divider that runs 64 steps for the rejection limit and again for
// the final modulo.
module pcg32_random_source_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [63:0] req_seed_value,
   input  wire logic [63:0] req_generation,
   input  wire logic [63:0] req_population_slot,
   input  wire logic [7:0]  req_domain_code,
   input  wire logic [63:0] req_range_bound,
   input  wire logic [32:0] req_chance,
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       rsp_status,
   output logic [63:0]      rsp_out_value,
   output logic             rsp_event_hit,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import pcg_pkg::*;

   logic [63:0] root_seed_ff;
   logic [7:0]  dom_first_ff, dom_last_ff;
   work_type    q_data;
   logic        q_valid, q_take, seeded;
   result_type  res;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_seed_ff <= '0;
         dom_first_ff <= 8'd0;
         dom_last_ff  <= 8'd3;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ROOT_SEED:    root_seed_ff <= csr_data;
            CSR_DOMAIN_FIRST: dom_first_ff <= csr_data[7:0];
            CSR_DOMAIN_LAST:  dom_last_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   pcg_front u_front (
      .clock, .reset, .push, .full,
      .opcode(req_opcode), .seed_value(req_seed_value),
      .generation(req_generation), .population_slot(req_population_slot),
      .domain_code(req_domain_code), .range_bound(req_range_bound),
      .chance(req_chance), .domain_first(dom_first_ff),
      .domain_last(dom_last_ff), .seeded,
      .q_data, .q_valid, .q_take
   );

   pcg_back u_back (
      .clock, .reset, .q_data, .q_valid, .q_take,
      .root_seed(root_seed_ff), .seeded, .res,
      .res_take(pop && !empty)
   );

   assign empty         = !res.valid;
   assign rsp_status    = res.status;
   assign rsp_out_value = res.value;
   assign rsp_event_hit = res.hit;

   assert property (@(posedge clock) disable iff (reset)
      (pop && !empty) |=> $past(rsp_status) == ST_OK || $past(rsp_out_value) == 64'd0)
      else $error("failed item carried a value");
endmodule
`default_nettype wire

FILE: design/pcg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pcg_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   output logic                     full,
   input  wire logic [2:0]          opcode,
   input  wire logic [63:0]         seed_value,
   input  wire logic [63:0]         generation,
   input  wire logic [63:0]         population_slot,
   input  wire logic [7:0]          domain_code,
   input  wire logic [63:0]         range_bound,
   input  wire logic [32:0]         chance,
   input  wire logic [7:0]          domain_first,
   input  wire logic [7:0]          domain_last,
   input  wire logic                seeded,
   output pcg_pkg::work_type        q_data,
   output logic                     q_valid,
   input  wire logic                q_take
);
   import pcg_pkg::*;

   localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   work_type           mem_ff [QUEUE_DEPTH];
   logic [AW-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]        cnt_ff, cnt_in;
   logic               seeded_ff, seeded_in;
   work_type           cls;
   logic               acc;

   // track seeded status ahead of the back end, since classification is early
   assign acc  = push && !full;
   assign full = (cnt_ff == (AW+1)'(QUEUE_DEPTH));

   always_comb begin
      cls.cmd         = CMD_FAIL;
      cls.fail_status = ST_BADARG;
      cls.arg_a       = seed_value;
      cls.arg_b       = range_bound;
      cls.dom         = domain_code;
      cls.chance      = chance;
      seeded_in       = seeded_ff;
      unique case (opcode)
         OP_SEED: begin
            cls.cmd   = CMD_SEED;
            seeded_in = 1'b1;
         end
         OP_DERIVE: begin
            cls.arg_a = generation;
            cls.arg_b = population_slot;
            if (domain_code >= domain_first && domain_code <= domain_last) begin
               cls.cmd   = CMD_DERIVE;
               seeded_in = 1'b1;
            end
         end
         OP_NEXT, OP_UNIF, OP_PROB: begin
            if (!seeded_ff) begin
               cls.fail_status = ST_UNSEEDED;
            end else if (opcode == OP_NEXT) begin
               cls.cmd = CMD_NEXT;
            end else if (opcode == OP_UNIF) begin
               if (range_bound != 64'd0) cls.cmd = CMD_UNIF;
            end else begin
               if (chance <= ONE_FIXED) cls.cmd = CMD_PROB;
            end
         end
         default: cls.cmd = CMD_FAIL;
      endcase
      if (!acc) seeded_in = seeded_ff;
   end

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (acc) begin
         wr_in = (wr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (q_take) begin
         rd_in = (rd_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (acc && !q_take) cnt_in = cnt_ff + 1'b1;
      else if (!acc && q_take) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff     <= '0;
         rd_ff     <= '0;
         cnt_ff    <= '0;
         seeded_ff <= 1'b0;
      end else begin
         wr_ff     <= wr_in;
         rd_ff     <= rd_in;
         cnt_ff    <= cnt_in;
         seeded_ff <= seeded_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) mem_ff[wr_ff] <= cls;
   end

   assign q_data  = mem_ff[rd_ff];
   assign q_valid = (cnt_ff != '0);

   assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid)
      else $error("queue read while empty");
   assert property (@(posedge clock) disable iff (reset)
      (acc && !q_take) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count lost a write");
   assert property (@(posedge clock) disable iff (reset)
      seeded |-> seeded_ff)
      else $error("front seeded flag behind back end");
endmodule
`default_nettype wire

FILE: design/pcg_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pcg_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire pcg_pkg::work_type   q_data,
   input  wire logic                q_valid,
   output logic                     q_take,
   input  wire logic [63:0]         root_seed,
   output logic                     seeded,
   output pcg_pkg::result_type      res,
   input  wire logic                res_take
);
   import pcg_pkg::*;

   back_state_type state_ff, state_in;
   work_type       job_ff;
   logic [63:0]    st_ff, inc_ff, acc_ff, mul_ff, x_ff;
   logic [63:0]    mat_ff, lim_ff, rem_ff, samp_ff;
   logic [31:0]    word_ff, lo_ff;
   logic [2:0]     mix_ff;      // which splitmix of derive
   logic [1:0]     step_ff;     // which word of a seed or uniform
   logic [1:0]     mph_ff;      // partial product phase of a 64-bit multiply
   logic           div_sel_ff;  // 0 limit, 1 sample mod
   logic [5:0]     dcnt_ff;
   logic           seeded_ff;
   result_type     res_ff;
   logic           out_free;

   logic [31:0]    xs, word;
   logic [4:0]     rot;
   logic [64:0]    rem_sh;
   logic [63:0]    div_n;
   logic [63:0]    mul_a, mul_b, pp, mix_out;
   logic [31:0]    pp_a, pp_b;
   logic           mul_last;

   assign out_free = !res_ff.valid || res_take;
   assign xs   = 32'(((st_ff >> 18) ^ st_ff) >> 27);
   assign rot  = st_ff[63:59];
   assign word = (xs >> rot) | (xs << (6'd32 - {1'b0, rot}));
   assign div_n = div_sel_ff ? samp_ff : (64'd0 - job_ff.arg_b);
   assign rem_sh = {rem_ff, div_n[6'd63 - dcnt_ff]};
   assign mix_out = mul_ff ^ (mul_ff >> 31);

   // one 32x32 multiplier; lo*lo, then lo*hi and hi*lo into the upper half
   assign mul_a = (state_ff == B_STEP_MUL) ? st_ff
                : (state_ff == B_MIX_MUL1) ? (x_ff ^ (x_ff >> 30)) : x_ff;
   assign mul_b = (state_ff == B_STEP_MUL) ? PCG_MULT
                : (state_ff == B_MIX_MUL1) ? MIX_M1 : MIX_M2;
   assign pp_a  = (mph_ff == 2'd2) ? mul_a[63:32] : mul_a[31:0];
   assign pp_b  = (mph_ff == 2'd1) ? mul_b[63:32] : mul_b[31:0];
   assign pp    = {32'd0, pp_a} * {32'd0, pp_b};
   assign mul_last = (mph_ff == 2'd2);

   always_comb begin
      state_in = state_ff;
      q_take   = 1'b0;
      unique case (state_ff)
         B_IDLE: if (q_valid && out_free) begin
            q_take = 1'b1;
            unique case (q_data.cmd)
               CMD_SEED:   state_in = B_STEP_MUL;
               CMD_DERIVE: state_in = B_MIX_XOR;
               CMD_NEXT, CMD_PROB: state_in = B_STEP_MUL;
               CMD_UNIF:   state_in = B_LIM_INIT;
               default:    state_in = B_RESULT;
            endcase
         end
         B_STEP_MUL: if (mul_last) state_in = B_STEP_ADD;
         B_STEP_ADD: begin
            priority if (job_ff.cmd == CMD_SEED)
               state_in = (step_ff == 2'd0) ? B_SEED_ADD : B_RESULT;
            else if (job_ff.cmd == CMD_UNIF)
               state_in = (step_ff == 2'd0) ? B_STEP_MUL : B_SAMPLE_CHK;
            else state_in = B_RESULT;
         end
         B_SEED_ADD: state_in = B_STEP_MUL;
         B_MIX_XOR:  state_in = B_MIX_MUL1;
         B_MIX_MUL1: if (mul_last) state_in = B_MIX_X2;
         B_MIX_X2:   state_in = B_MIX_MUL2;
         B_MIX_MUL2: if (mul_last) state_in = B_MIX_DONE;
         B_MIX_DONE: state_in = (mix_ff == 3'd5) ? B_RESULT : B_MIX_XOR;
         B_LIM_INIT: state_in = B_LIM_DIV;
         B_LIM_DIV:  if (dcnt_ff == 6'd63) state_in = B_DIV_DONE;
         B_DIV_DONE: state_in = div_sel_ff ? B_RESULT : B_STEP_MUL;
         B_SAMPLE_CHK: state_in = (samp_ff < lim_ff) ? B_STEP_MUL : B_LIM_INIT;
         B_RESULT:   state_in = B_IDLE;
         default:    state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         seeded_ff <= 1'b0;
         res_ff.valid <= 1'b0;
         st_ff  <= '0;
         inc_ff <= '0;
         mph_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (res_take) res_ff.valid <= 1'b0;
         unique case (state_ff)
            B_IDLE: if (q_take) begin
               job_ff  <= q_data;
               step_ff <= '0;
               mix_ff  <= '0;
               div_sel_ff <= 1'b0;
               acc_ff  <= '0;
               if (q_data.cmd == CMD_SEED) begin
                  st_ff  <= '0;
                  inc_ff <= PCG_INC;
               end
            end
            B_STEP_MUL, B_MIX_MUL1, B_MIX_MUL2: begin
               if (state_ff == B_STEP_MUL) word_ff <= word;
               if (mph_ff == 2'd0) mul_ff <= pp;
               else mul_ff <= {mul_ff[63:32] + pp[31:0], mul_ff[31:0]};
               mph_ff <= mul_last ? 2'd0 : mph_ff + 2'd1;
            end
            B_STEP_ADD: begin
               st_ff   <= mul_ff + inc_ff;
               step_ff <= (job_ff.cmd == CMD_UNIF && step_ff == 2'd1) ? 2'd0
                        : step_ff + 2'd1;
               if (step_ff == 2'd0) lo_ff <= word_ff;
               samp_ff <= {word_ff, lo_ff};
            end
            B_SEED_ADD: st_ff <= st_ff + job_ff.arg_a;
            B_MIX_XOR: begin
               // derive: g, p, d mixes fold into acc; then mat, state, stream
               unique case (mix_ff)
                  3'd0: x_ff <= job_ff.arg_a ^ TAG_GEN;
                  3'd1: x_ff <= job_ff.arg_b ^ TAG_POP;
                  3'd2: x_ff <= {56'd0, job_ff.dom} ^ TAG_DOM;
                  3'd3: x_ff <= root_seed ^ acc_ff;
                  3'd4: x_ff <= mat_ff ^ TAG_STATE;
                  3'd5: x_ff <= {mat_ff[63-STREAM_ROT:0], mat_ff[63:64-STREAM_ROT]}
                                ^ TAG_STREAM;
                  default: x_ff <= '0;
               endcase
            end
            B_MIX_X2:   x_ff   <= mul_ff ^ (mul_ff >> 27);
            B_MIX_DONE: begin
               x_ff   <= mix_out;
               mix_ff <= mix_ff + 3'd1;
               unique case (mix_ff)
                  3'd0, 3'd1, 3'd2: acc_ff <= acc_ff ^ mix_out;
                  3'd3: mat_ff <= mix_out;
                  3'd4: acc_ff <= mix_out;
                  default: begin
                     st_ff  <= acc_ff;
                     inc_ff <= {mix_out[62:0], 1'b1};
                  end
               endcase
            end
            B_LIM_INIT: begin
               rem_ff  <= '0;
               dcnt_ff <= '0;
            end
            B_LIM_DIV: begin
               // restoring divide, one quotient bit per cycle
               if (rem_sh >= {1'b0, job_ff.arg_b}) rem_ff <= 64'(rem_sh - {1'b0, job_ff.arg_b});
               else rem_ff <= rem_sh[63:0];
               dcnt_ff <= dcnt_ff + 6'd1;
            end
            B_DIV_DONE: begin
               if (!div_sel_ff) lim_ff <= rem_ff;
            end
            B_SAMPLE_CHK: if (samp_ff >= lim_ff) div_sel_ff <= 1'b1;
            B_RESULT: begin
               res_ff.valid  <= 1'b1;
               res_ff.status <= (job_ff.cmd == CMD_FAIL) ? job_ff.fail_status : ST_OK;
               res_ff.value  <= (job_ff.cmd == CMD_NEXT) ? {32'd0, word_ff}
                              : (job_ff.cmd == CMD_UNIF) ? rem_ff : 64'd0;
               res_ff.hit    <= (job_ff.cmd == CMD_PROB)
                              && ({1'b0, word_ff} < job_ff.chance);
               if (job_ff.cmd == CMD_SEED || job_ff.cmd == CMD_DERIVE)
                  seeded_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign res    = res_ff;
   assign seeded = seeded_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RESULT) |-> out_free)
      else $error("result overwritten before taken");
   assert property (@(posedge clock) disable iff (reset)
      q_take |-> state_ff == B_IDLE)
      else $error("took work while busy");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RESULT) |=> res_ff.valid)
      else $error("result not posted");
endmodule
`default_nettype wire
